### sv/ctfwd_pkg.sv
package ctfwd_pkg;

  localparam int unsigned VectorLengthDef = 64;
  localparam int unsigned AddrW           = 6;
  localparam int unsigned WinLenW         = 7;
  localparam logic [WinLenW-1:0] WinLenRst = 7'd16;
  localparam int unsigned CordicSteps     = 31;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam longint ArcTurns [CordicSteps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001
  };

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INV,
    OP_FWD,
    OP_SUM
  } op_e;

  typedef struct packed {
    logic             smp_wr;
    logic [AddrW-1:0] wr_addr;
    op_e              op;
    logic             first;
    logic             last;
    logic [AddrW-1:0] rd_addr;
    logic [AddrW-1:0] tw_idx;
    logic             keep;
    logic             div_start;
    logic             tap_wr;
    logic             best_clr;
    logic             cmp;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic             mac_done;
    logic             div_busy;
    logic             out_free;
    logic [AddrW-1:0] best_start;
  } status_t;

  // cos and sin in q2.30 of a 32-bit angle in turns, packed {sin, cos}
  function automatic logic [63:0] twiddle_cs(input logic [31:0] ang);
    longint a;
    longint q;
    longint z;
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint c;
    longint s;
    int     i;
    a = longint'({32'd0, ang});
    q = (a + 64'sd536870912) >>> 30;
    z = a - (q <<< 30);
    x = 64'sd652032874;
    y = 64'sd0;
    for (i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ArcTurns[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ArcTurns[i];
      end
      x = nx;
      y = ny;
    end
    case (q[1:0])
      2'd0: begin
        nx = x;
        ny = y;
      end
      2'd1: begin
        nx = -y;
        ny = x;
      end
      2'd2: begin
        nx = -x;
        ny = -y;
      end
      default: begin
        nx = y;
        ny = -x;
      end
    endcase
    c = (nx > 64'sd1073741824) ? 64'sd1073741824 :
        (nx < -64'sd1073741824) ? -64'sd1073741824 : nx;
    s = (ny > 64'sd1073741824) ? 64'sd1073741824 :
        (ny < -64'sd1073741824) ? -64'sd1073741824 : ny;
    return {s[31:0], c[31:0]};
  endfunction

endpackage

### sv/ctfwd_datapath.sv
module ctfwd_datapath #(
  parameter int unsigned VECTOR_LENGTH = ctfwd_pkg::VectorLengthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctfwd_pkg::cmd_t                cmd_i,
  output ctfwd_pkg::status_t             status_o,
  input  logic signed [15:0]             sample_re_i,
  input  logic signed [15:0]             sample_im_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic signed [15:0]             out_re_o,
  output logic signed [15:0]             out_im_o,
  output logic [ctfwd_pkg::AddrW-1:0]    window_start_o,
  output logic                           last_out_o
);

  localparam int unsigned IdxW    = $clog2(VECTOR_LENGTH);
  localparam int unsigned AccW    = 56;
  localparam int unsigned VW      = AccW - 30;
  localparam int unsigned RcpSh   = VW + IdxW;
  localparam logic [VW:0] Rcp     = (VW + 1)'(((64'd1 << RcpSh) + 64'(VECTOR_LENGTH) - 64'd1) /
                                              64'(VECTOR_LENGTH));
  localparam logic [AccW-1:0] InvBias = AccW'(VECTOR_LENGTH) << 29;
  localparam logic [AccW-1:0] FwdBias = AccW'(1) << 29;

  // twiddle table, worked out at elaboration
  logic signed [31:0] tw_cos [VECTOR_LENGTH];
  logic signed [31:0] tw_sin [VECTOR_LENGTH];

  for (genvar m = 0; m < VECTOR_LENGTH; m++) begin : g_tw
    localparam logic [63:0] AngFull = ((64'(m) << 32) + 64'(VECTOR_LENGTH / 2)) /
                                      64'(VECTOR_LENGTH);
    localparam logic [63:0] Cs = ctfwd_pkg::twiddle_cs(AngFull[31:0]);
    assign tw_cos[m] = Cs[31:0];
    assign tw_sin[m] = Cs[63:32];
  end

  function automatic logic [VW-1:0] round_mag(input logic signed [AccW-1:0] v,
                                              input logic [AccW-1:0] bias);
    logic [AccW-1:0] mg;
    logic [AccW-1:0] sh;
    mg = v[AccW-1] ? AccW'(-v) : AccW'(v);
    sh = (mg + bias) >> 30;
    return sh[VW-1:0];
  endfunction

  function automatic logic signed [15:0] sat_mag(input logic neg, input logic [VW-1:0] q);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > VW'(32768)) ? 16'sh8000 : 16'(~q + VW'(1));
    end else begin
      r = (q > VW'(32767)) ? 16'sh7fff : q[15:0];
    end
    return r;
  endfunction

  logic [31:0] smp_mem [VECTOR_LENGTH];
  logic [31:0] imp_mem [VECTOR_LENGTH];
  logic [31:0] pwr_mem [VECTOR_LENGTH];

  logic [31:0]        rd_smp_q, rd_imp_q, rd_pwr_q;
  logic signed [31:0] tw_c_q, tw_s_q;
  logic               keep1_q;
  ctfwd_pkg::op_e     op1_q, op2_q;
  logic               first1_q, last1_q, first2_q, last2_q, done_q;

  logic signed [15:0] xr, xi;
  logic signed [47:0] p_rc_q, p_is_q, p_rs_q, p_ic_q;
  logic [31:0]        pwr2_q;

  logic signed [AccW-1:0] acc_q  [2];
  logic signed [AccW-1:0] term   [2];
  logic [39:0]            wsum_q;

  logic               neg_q  [2];
  logic [VW-1:0]      dvd_q  [2];
  logic [2*VW:0]      prod_q [2];
  logic               div_busy_q;

  logic signed [15:0] tap_re, tap_im;
  logic signed [31:0] sq_re, sq_im;
  logic [31:0]        tap_pwr;

  logic [IdxW-1:0]    best_q;
  logic [39:0]        best_sum_q;

  logic               out_valid_q, out_last_q;
  logic signed [15:0] out_re_q, out_im_q;
  logic [ctfwd_pkg::AddrW-1:0] out_ws_q;

  // stores and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_wr) begin
      smp_mem[cmd_i.wr_addr[IdxW-1:0]] <= {sample_im_i, sample_re_i};
    end
    if (cmd_i.tap_wr) begin
      imp_mem[cmd_i.wr_addr[IdxW-1:0]] <= {tap_im, tap_re};
      pwr_mem[cmd_i.wr_addr[IdxW-1:0]] <= tap_pwr;
    end
    rd_smp_q <= smp_mem[cmd_i.rd_addr[IdxW-1:0]];
    rd_imp_q <= imp_mem[cmd_i.rd_addr[IdxW-1:0]];
    rd_pwr_q <= pwr_mem[cmd_i.rd_addr[IdxW-1:0]];
    tw_c_q   <= tw_cos[cmd_i.tw_idx[IdxW-1:0]];
    tw_s_q   <= tw_sin[cmd_i.tw_idx[IdxW-1:0]];
    keep1_q  <= cmd_i.keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q    <= ctfwd_pkg::OP_NONE;
      op2_q    <= ctfwd_pkg::OP_NONE;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      op1_q    <= cmd_i.op;
      first1_q <= cmd_i.first;
      last1_q  <= cmd_i.last;
      op2_q    <= op1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= (op2_q != ctfwd_pkg::OP_NONE) && last2_q;
    end
  end

  // product stage
  always_comb begin
    if (op1_q == ctfwd_pkg::OP_FWD) begin
      xr = keep1_q ? rd_imp_q[15:0]  : 16'sd0;
      xi = keep1_q ? rd_imp_q[31:16] : 16'sd0;
    end else begin
      xr = rd_smp_q[15:0];
      xi = rd_smp_q[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    p_rc_q <= xr * tw_c_q;
    p_is_q <= xi * tw_s_q;
    p_rs_q <= xr * tw_s_q;
    p_ic_q <= xi * tw_c_q;
    pwr2_q <= rd_pwr_q;
  end

  // accumulate stage
  always_comb begin
    case (op2_q)
      ctfwd_pkg::OP_INV: begin
        term[0] = AccW'(p_rc_q) - AccW'(p_is_q);
        term[1] = AccW'(p_rs_q) + AccW'(p_ic_q);
      end
      ctfwd_pkg::OP_FWD: begin
        term[0] = AccW'(p_rc_q) + AccW'(p_is_q);
        term[1] = AccW'(p_ic_q) - AccW'(p_rs_q);
      end
      default: begin
        term[0] = '0;
        term[1] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op2_q == ctfwd_pkg::OP_INV || op2_q == ctfwd_pkg::OP_FWD) begin
      for (int l = 0; l < 2; l++) begin
        acc_q[l] <= first2_q ? term[l] : acc_q[l] + term[l];
      end
    end
    if (op2_q == ctfwd_pkg::OP_SUM) begin
      wsum_q <= first2_q ? 40'(pwr2_q) : wsum_q + 40'(pwr2_q);
    end
  end

  // divide by the vector length: round first, then multiply by the reciprocal
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.div_start) begin
        neg_q[l] <= acc_q[l][AccW-1];
        dvd_q[l] <= round_mag(acc_q[l], InvBias);
      end
      if (div_busy_q) begin
        prod_q[l] <= dvd_q[l] * Rcp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else begin
      div_busy_q <= cmd_i.div_start;
    end
  end

  assign tap_re  = sat_mag(neg_q[0], VW'(prod_q[0] >> RcpSh));
  assign tap_im  = sat_mag(neg_q[1], VW'(prod_q[1] >> RcpSh));
  assign sq_re   = tap_re * tap_re;
  assign sq_im   = tap_im * tap_im;
  assign tap_pwr = 32'(sq_re) + 32'(sq_im);

  // best window so far
  always_ff @(posedge clk_i) begin
    if (cmd_i.best_clr) begin
      best_q     <= '0;
      best_sum_q <= '0;
    end else if (cmd_i.cmp && (wsum_q > best_sum_q)) begin
      best_q     <= cmd_i.wr_addr[IdxW-1:0];
      best_sum_q <= wsum_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_q   <= sat_mag(acc_q[0][AccW-1], round_mag(acc_q[0], FwdBias));
      out_im_q   <= sat_mag(acc_q[1][AccW-1], round_mag(acc_q[1], FwdBias));
      out_last_q <= cmd_i.out_last;
      out_ws_q   <= ctfwd_pkg::AddrW'(best_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_re_o       = out_re_q;
  assign out_im_o       = out_im_q;
  assign window_start_o = out_ws_q;
  assign last_out_o     = out_last_q;

  assign status_o.mac_done   = done_q;
  assign status_o.div_busy   = div_busy_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.best_start = ctfwd_pkg::AddrW'(best_q);

endmodule

### sv/ctfwd_ctrl.sv
module ctfwd_ctrl #(
  parameter int unsigned VECTOR_LENGTH = ctfwd_pkg::VectorLengthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            window_length_we_i,
  input  logic [ctfwd_pkg::WinLenW-1:0]   window_length_i,
  input  ctfwd_pkg::status_t              status_i,
  output ctfwd_pkg::cmd_t                 cmd_o
);

  localparam int unsigned IdxW = $clog2(VECTOR_LENGTH);
  localparam int unsigned LenW = ctfwd_pkg::WinLenW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VECTOR_LENGTH - 1);
  localparam logic [IdxW:0]   NExt    = (IdxW + 1)'(VECTOR_LENGTH);

  localparam logic [3:0] S_COLLECT  = 4'd0;
  localparam logic [3:0] S_INV_MAC  = 4'd1;
  localparam logic [3:0] S_INV_WAIT = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_TAP_WR   = 4'd4;
  localparam logic [3:0] S_SUM_MAC  = 4'd5;
  localparam logic [3:0] S_SUM_WAIT = 4'd6;
  localparam logic [3:0] S_FWD_MAC  = 4'd7;
  localparam logic [3:0] S_FWD_WAIT = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d, outer_q, outer_d, m_q, m_d, a_q, a_d;
  logic [LenW-1:0] wl_q, len;
  logic [IdxW:0]   m_sum, dd;
  logic [IdxW-1:0] m_nx, a_nx, best;
  logic            keep, cnt_end, len_end;

  assign len     = (wl_q > LenW'(VECTOR_LENGTH)) ? LenW'(VECTOR_LENGTH) : wl_q;
  assign m_sum   = {1'b0, m_q} + {1'b0, outer_q};
  assign m_nx    = (m_sum >= NExt) ? IdxW'(m_sum - NExt) : IdxW'(m_sum);
  assign a_nx    = (a_q == LastIdx) ? '0 : a_q + IdxW'(1);
  assign best    = status_i.best_start[IdxW-1:0];
  assign dd      = {1'b0, cnt_q} + NExt - {1'b0, best};
  assign keep    = (LenW'((dd >= NExt) ? dd - NExt : dd) < len);
  assign cnt_end = (cnt_q == LastIdx);
  assign len_end = (LenW'(cnt_q) == len - LenW'(1));

  assign in_stall_o = (state_q != S_COLLECT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    outer_d = outer_q;
    m_d     = m_q;
    a_d     = a_q;
    cmd_o   = '0;
    cmd_o.op      = ctfwd_pkg::OP_NONE;
    cmd_o.wr_addr = ctfwd_pkg::AddrW'(outer_q);
    cmd_o.rd_addr = ctfwd_pkg::AddrW'(cnt_q);
    cmd_o.tw_idx  = ctfwd_pkg::AddrW'(m_q);
    unique case (state_q)
      S_COLLECT: begin
        cmd_o.wr_addr = ctfwd_pkg::AddrW'(cnt_q);
        if (in_valid_i) begin
          cmd_o.smp_wr = 1'b1;
          if (cnt_end) begin
            cnt_d   = '0;
            outer_d = '0;
            m_d     = '0;
            state_d = S_INV_MAC;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      S_INV_MAC, S_FWD_MAC: begin
        cmd_o.op    = (state_q == S_INV_MAC) ? ctfwd_pkg::OP_INV : ctfwd_pkg::OP_FWD;
        cmd_o.first = (cnt_q == '0);
        cmd_o.last  = cnt_end;
        cmd_o.keep  = keep;
        m_d = m_nx;
        if (cnt_end) begin
          cnt_d   = '0;
          m_d     = '0;
          state_d = (state_q == S_INV_MAC) ? S_INV_WAIT : S_FWD_WAIT;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_INV_WAIT: begin
        if (status_i.mac_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_TAP_WR;
        end
      end
      S_TAP_WR: begin
        cmd_o.tap_wr = 1'b1;
        if (outer_q == LastIdx) begin
          cmd_o.best_clr = 1'b1;
          outer_d = '0;
          cnt_d   = '0;
          a_d     = '0;
          state_d = (len == '0) ? S_FWD_MAC : S_SUM_MAC;
        end else begin
          outer_d = outer_q + IdxW'(1);
          state_d = S_INV_MAC;
        end
      end
      S_SUM_MAC: begin
        cmd_o.op      = ctfwd_pkg::OP_SUM;
        cmd_o.rd_addr = ctfwd_pkg::AddrW'(a_q);
        cmd_o.first   = (cnt_q == '0);
        cmd_o.last    = len_end;
        a_d = a_nx;
        if (len_end) begin
          cnt_d   = '0;
          state_d = S_SUM_WAIT;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_SUM_WAIT: begin
        if (status_i.mac_done) begin
          cmd_o.cmp = 1'b1;
          if (outer_q == LastIdx) begin
            outer_d = '0;
            cnt_d   = '0;
            m_d     = '0;
            state_d = S_FWD_MAC;
          end else begin
            outer_d = outer_q + IdxW'(1);
            a_d     = outer_q + IdxW'(1);
            state_d = S_SUM_MAC;
          end
        end
      end
      S_FWD_WAIT: begin
        if (status_i.mac_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (outer_q == LastIdx);
          if (outer_q == LastIdx) begin
            outer_d = '0;
            cnt_d   = '0;
            state_d = S_COLLECT;
          end else begin
            outer_d = outer_q + IdxW'(1);
            state_d = S_FWD_MAC;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      cnt_q   <= '0;
      outer_q <= '0;
      m_q     <= '0;
      a_q     <= '0;
      wl_q    <= ctfwd_pkg::WinLenRst;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      outer_q <= outer_d;
      m_q     <= m_d;
      a_q     <= a_d;
      if (window_length_we_i) begin
        wl_q <= window_length_i;
      end
    end
  end

endmodule

### sv/ctf_cir_window_denoiser.sv
// channel   dir  signals                                       handshake
// input     in   sample_re_i sample_im_i                       in_valid_i / in_stall_o
// output    out  out_re_o out_im_o window_start_o last_out_o   out_valid_o / out_stall_i
// config    in   window_length_i                               window_length_we_i
//
// collection takes one sample a cycle; then one shared complex mac runs the
// inverse transform (incl. the per-tap reciprocal divide), the window search
// (skipped for a zero length) and the forward transform, which holds on output stalls
// inputs are stalled from the last sample of a vector until its final result is loaded
// reset is asynchronous, active low; window_length returns to 16
module ctf_cir_window_denoiser #(
  parameter int unsigned VECTOR_LENGTH = ctfwd_pkg::VectorLengthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transactions
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            sample_re_i,
  input  logic signed [15:0]            sample_im_i,
  // window length register
  input  logic                          window_length_we_i,
  input  logic [ctfwd_pkg::WinLenW-1:0] window_length_i,
  // output transactions
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            out_re_o,
  output logic signed [15:0]            out_im_o,
  output logic [ctfwd_pkg::AddrW-1:0]   window_start_o,
  output logic                          last_out_o
);

  // commands down to the datapath, status back up
  ctfwd_pkg::cmd_t    cmd;
  ctfwd_pkg::status_t status;

  // sequencer: sample count, transform loops, window search, output pacing
  ctfwd_ctrl #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .window_length_we_i(window_length_we_i),
    .window_length_i   (window_length_i),
    .status_i          (status),
    .cmd_o             (cmd)
  );

  // stores, twiddle table, mac pipeline, divider, best window and output register
  ctfwd_datapath #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_re_o      (out_re_o),
    .out_im_o      (out_im_o),
    .window_start_o(window_start_o),
    .last_out_o    (last_out_o)
  );

endmodule

### sv/ctfwd_checker.sv
module ctfwd_checker #(
  parameter int unsigned VECTOR_LENGTH = ctfwd_pkg::VectorLengthDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [15:0]            out_re_o,
  input logic signed [15:0]            out_im_o,
  input logic [ctfwd_pkg::AddrW-1:0]   window_start_o,
  input logic                          last_out_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_re_o) && $stable(out_im_o))
    else $error("stalled result changed");

  // no sample taken while a vector is still being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_out_o |-> in_stall_o)
    else $error("input taken during output");

  // window start within the vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_start_o < VECTOR_LENGTH))
    else $error("window start out of range");

endmodule

bind ctf_cir_window_denoiser ctfwd_checker #(
  .VECTOR_LENGTH(VECTOR_LENGTH)
) u_ctfwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_re_o      (out_re_o),
  .out_im_o      (out_im_o),
  .window_start_o(window_start_o),
  .last_out_o    (last_out_o)
);
